FILE: src/dms_pkg.sv
// shared types, codes and constants of the drive mode supervisor
package dms_pkg;

   localparam int OFFSET_W   = 12;
   localparam int PULSE_US_W = 12;
   localparam int COUNT_SHIFT = 4;   // sixteen timer counts per microsecond

   localparam logic [OFFSET_W-1:0]   OFFSET_RESET   = 12'd1500;
   localparam logic [PULSE_US_W-1:0] PULSE_RESET_US = 12'd1500;
   localparam logic signed [15:0]    CRAWL_TARGET   = 16'sd50;

   // item operations
   localparam logic [3:0] OP_TICK       = 4'd0;
   localparam logic [3:0] OP_STEER      = 4'd1;
   localparam logic [3:0] OP_THR_OPEN   = 4'd2;
   localparam logic [3:0] OP_THR_CLOSED = 4'd3;
   localparam logic [3:0] OP_CRAWL      = 4'd4;
   localparam logic [3:0] OP_ARM        = 4'd5;
   localparam logic [3:0] OP_KEEPALIVE  = 4'd6;
   localparam logic [3:0] OP_DISARM     = 4'd7;
   localparam logic [3:0] OP_ODO_RESET  = 4'd8;

   // failure codes
   localparam logic [2:0] FAIL_NONE       = 3'd0;
   localparam logic [2:0] FAIL_CHECKSUM   = 3'd1;
   localparam logic [2:0] FAIL_DISABLED   = 3'd2;
   localparam logic [2:0] FAIL_ACTIVE     = 3'd3;
   localparam logic [2:0] FAIL_TRANSITION = 3'd4;

   // kill-switch commands
   localparam logic [1:0] RCMD_NONE      = 2'd0;
   localparam logic [1:0] RCMD_ARM       = 2'd1;
   localparam logic [1:0] RCMD_KEEPALIVE = 2'd2;
   localparam logic [1:0] RCMD_DISARM    = 2'd3;

   // kill-switch states
   localparam logic [2:0] RSTATE_DISARMED     = 3'd0;
   localparam logic [2:0] RSTATE_DISARM_REQ   = 3'd1;
   localparam logic [2:0] RSTATE_DISARM_REMOTE = 3'd2;
   localparam logic [2:0] RSTATE_DISARM_SW    = 3'd3;
   localparam logic [2:0] RSTATE_ARMED        = 3'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_STEER_LEFT  = 2'd0;
   localparam logic [1:0] CSR_STEER_RIGHT = 2'd1;
   localparam logic [1:0] CSR_THR_FWD     = 2'd2;
   localparam logic [1:0] CSR_THR_BWD     = 2'd3;

   typedef enum logic [2:0] {
      MODE_DISABLED   = 3'd0,
      MODE_DISABLING  = 3'd1,
      MODE_STOPPED    = 3'd2,
      MODE_FWD_OPEN   = 3'd3,
      MODE_BWD_OPEN   = 3'd4,
      MODE_FWD_CLOSED = 3'd5,
      MODE_BWD_CLOSED = 3'd6,
      MODE_CRAWL      = 3'd7
   } mode_type;

   typedef struct packed {
      logic [3:0]         op;
      logic               check_ok;
      logic signed [15:0] target;
      logic signed [15:0] tick_delta;
      logic signed [15:0] loop_output;
      logic               bumper_hit;
      logic               remote_valid;
      logic [2:0]         remote_state;
   } req_type;

   typedef struct packed {
      logic               ack;
      logic [2:0]         failure;
      logic [2:0]         mode_out;
      logic [15:0]        throttle_counts;
      logic [15:0]        steering_counts;
      logic               loop_enable;
      logic signed [15:0] target_out;
      logic               loop_reset;
      logic [1:0]         remote_command;
      logic signed [31:0] odometer;
      logic               report_valid;
   } rsp_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] steer_left;
      logic [OFFSET_W-1:0] steer_right;
      logic [OFFSET_W-1:0] thr_fwd;
      logic [OFFSET_W-1:0] thr_bwd;
   } csr_type;

endpackage

FILE: src/dms_csr.sv
// deadzone offset registers written through the csr port
module dms_csr (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   input  logic [1:0]              csr_index,
   input  logic [11:0]             csr_wdata,
   output logic                    csr_ready,
   output dms_pkg::csr_type        offsets
);

   dms_pkg::csr_type offsets_ff;
   dms_pkg::csr_type offsets_in;

   assign csr_ready = 1'b1;
   assign offsets   = offsets_ff;

   always_comb begin
      offsets_in = offsets_ff;
      if (csr_valid) begin
         unique case (csr_index)
            dms_pkg::CSR_STEER_LEFT:  offsets_in.steer_left  = csr_wdata;
            dms_pkg::CSR_STEER_RIGHT: offsets_in.steer_right = csr_wdata;
            dms_pkg::CSR_THR_FWD:     offsets_in.thr_fwd     = csr_wdata;
            dms_pkg::CSR_THR_BWD:     offsets_in.thr_bwd     = csr_wdata;
            default:                  offsets_in = offsets_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offsets_ff.steer_left  <= dms_pkg::OFFSET_RESET;
         offsets_ff.steer_right <= dms_pkg::OFFSET_RESET;
         offsets_ff.thr_fwd     <= dms_pkg::OFFSET_RESET;
         offsets_ff.thr_bwd     <= dms_pkg::OFFSET_RESET;
      end else begin
         offsets_ff <= offsets_in;
      end
   end

endmodule

FILE: src/dms_pulse.sv
// signed value to saturated pulse width in microseconds
module dms_pulse (
   input  logic signed [15:0] value,
   input  logic [11:0]        pos_offset,
   input  logic [11:0]        neg_offset,
   output logic [11:0]        width_us
);

   logic [12:0]        offset_sum;
   logic [11:0]        offset_mean;
   logic signed [17:0] width_raw;

   always_comb begin
      offset_sum  = {1'b0, pos_offset} + {1'b0, neg_offset};
      offset_mean = offset_sum[12:1];
      if (value > 16'sd0) begin
         width_raw = 18'(value) + $signed({6'b0, pos_offset});
      end else if (value < 16'sd0) begin
         width_raw = 18'(value) + $signed({6'b0, neg_offset});
      end else begin
         width_raw = $signed({6'b0, offset_mean});
      end
      // clamp to 0..4095 us
      if (width_raw < 18'sd0) begin
         width_us = '0;
      end else if (width_raw > 18'sd4095) begin
         width_us = '1;
      end else begin
         width_us = width_raw[11:0];
      end
   end

endmodule

FILE: src/dms_core.sv
// mode state, command checks and tick handling for one item
module dms_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  dms_pkg::req_type  item,
   input  dms_pkg::csr_type  offsets,
   output dms_pkg::rsp_type  result
);

   dms_pkg::mode_type  mode_ff, mode_in, mode_after_stop;
   logic signed [15:0] target_ff, target_in;
   logic               closed_ff, closed_in;
   logic [31:0]        odom_ff, odom_in;
   logic [11:0]        thr_us_ff, thr_us_in, thr_us_new;
   logic [11:0]        steer_us_ff, steer_us_in, steer_us_new;

   logic               is_tick, cmd_known, cmd_ok, disabled;
   logic               fwd_dir, bwd_dir;
   logic               bump_stop, rest_stop, motion_stop, remote_disarm;
   logic signed [15:0] thr_gated, thr_value;
   logic [2:0]         cmd_fail;

   dms_pulse u_thr_pulse (
      .value      (thr_value),
      .pos_offset (offsets.thr_fwd),
      .neg_offset (offsets.thr_bwd),
      .width_us   (thr_us_new)
   );

   dms_pulse u_steer_pulse (
      .value      (item.target),
      .pos_offset (offsets.steer_left),
      .neg_offset (offsets.steer_right),
      .width_us   (steer_us_new)
   );

   // tick path: direction gating, stop conditions, kill-switch
   always_comb begin
      is_tick  = (item.op == dms_pkg::OP_TICK);
      disabled = (mode_ff == dms_pkg::MODE_DISABLED) || (mode_ff == dms_pkg::MODE_DISABLING);
      fwd_dir  = mode_ff inside {dms_pkg::MODE_FWD_OPEN, dms_pkg::MODE_FWD_CLOSED,
                                 dms_pkg::MODE_CRAWL};
      bwd_dir  = mode_ff inside {dms_pkg::MODE_BWD_OPEN, dms_pkg::MODE_BWD_CLOSED};

      thr_gated = '0;
      if (fwd_dir && item.loop_output >= 16'sd0) begin
         thr_gated = item.loop_output;
      end else if (bwd_dir && item.loop_output <= 16'sd0) begin
         thr_gated = item.loop_output;
      end

      bump_stop   = (mode_ff == dms_pkg::MODE_CRAWL) && item.bumper_hit;
      rest_stop   = !bump_stop && (mode_ff >= dms_pkg::MODE_FWD_OPEN)
                    && (item.tick_delta == 16'sd0) && (target_ff == 16'sd0);
      motion_stop = bump_stop || rest_stop;
      mode_after_stop = motion_stop ? dms_pkg::MODE_STOPPED : mode_ff;

      remote_disarm = item.remote_valid
                      && (item.remote_state >= dms_pkg::RSTATE_DISARM_REQ)
                      && (item.remote_state <= dms_pkg::RSTATE_DISARM_SW)
                      && (mode_after_stop != dms_pkg::MODE_DISABLING);

      thr_value = (motion_stop || remote_disarm) ? 16'sd0 : thr_gated;
   end

   // command checks
   always_comb begin
      cmd_known = (item.op >= dms_pkg::OP_STEER) && (item.op <= dms_pkg::OP_ODO_RESET);
      cmd_ok    = cmd_known && item.check_ok;
      cmd_fail  = dms_pkg::FAIL_NONE;
      unique case (item.op)
         dms_pkg::OP_THR_OPEN: begin
            if (disabled) begin
               cmd_fail = dms_pkg::FAIL_DISABLED;
            end else if (mode_ff == dms_pkg::MODE_STOPPED) begin
               cmd_fail = dms_pkg::FAIL_NONE;
            end else if (fwd_dir) begin
               if (item.target < 16'sd0) cmd_fail = dms_pkg::FAIL_TRANSITION;
            end else begin
               if (item.target > 16'sd0) cmd_fail = dms_pkg::FAIL_TRANSITION;
            end
         end
         dms_pkg::OP_THR_CLOSED: begin
            if (disabled) begin
               cmd_fail = dms_pkg::FAIL_DISABLED;
            end else if (mode_ff == dms_pkg::MODE_STOPPED) begin
               cmd_fail = dms_pkg::FAIL_NONE;
            end else if (mode_ff == dms_pkg::MODE_FWD_CLOSED
                         || mode_ff == dms_pkg::MODE_CRAWL) begin
               if (item.target < 16'sd0) cmd_fail = dms_pkg::FAIL_TRANSITION;
            end else if (mode_ff == dms_pkg::MODE_BWD_CLOSED) begin
               if (item.target > 16'sd0) cmd_fail = dms_pkg::FAIL_TRANSITION;
            end else begin
               cmd_fail = dms_pkg::FAIL_TRANSITION;
            end
         end
         dms_pkg::OP_CRAWL: begin
            if (disabled) begin
               cmd_fail = dms_pkg::FAIL_DISABLED;
            end else if (!(mode_ff inside {dms_pkg::MODE_STOPPED, dms_pkg::MODE_CRAWL,
                                           dms_pkg::MODE_FWD_CLOSED})) begin
               cmd_fail = dms_pkg::FAIL_TRANSITION;
            end
         end
         dms_pkg::OP_ARM: begin
            if (mode_ff != dms_pkg::MODE_DISABLED) cmd_fail = dms_pkg::FAIL_ACTIVE;
         end
         dms_pkg::OP_KEEPALIVE: begin
            if (disabled) cmd_fail = dms_pkg::FAIL_DISABLED;
         end
         default: cmd_fail = dms_pkg::FAIL_NONE;
      endcase
   end

   // next state
   always_comb begin
      mode_in     = mode_ff;
      target_in   = target_ff;
      closed_in   = closed_ff;
      odom_in     = odom_ff;
      thr_us_in   = thr_us_ff;
      steer_us_in = steer_us_ff;
      if (is_tick) begin
         odom_in   = odom_ff + 32'(item.tick_delta);
         thr_us_in = thr_us_new;
         mode_in   = mode_after_stop;
         if (motion_stop || remote_disarm) target_in = '0;
         if (item.remote_valid) begin
            if (item.remote_state == dms_pkg::RSTATE_DISARMED) begin
               mode_in = dms_pkg::MODE_DISABLED;
            end else if (item.remote_state <= dms_pkg::RSTATE_DISARM_SW) begin
               mode_in = dms_pkg::MODE_DISABLING;
            end else if (item.remote_state == dms_pkg::RSTATE_ARMED
                         && (mode_after_stop == dms_pkg::MODE_DISABLED
                             || mode_after_stop == dms_pkg::MODE_DISABLING)) begin
               mode_in = dms_pkg::MODE_STOPPED;
            end
         end
      end else if (cmd_ok && cmd_fail == dms_pkg::FAIL_NONE) begin
         unique case (item.op)
            dms_pkg::OP_STEER: steer_us_in = steer_us_new;
            dms_pkg::OP_THR_OPEN: begin
               if (mode_ff == dms_pkg::MODE_STOPPED) begin
                  if (item.target > 16'sd0) mode_in = dms_pkg::MODE_FWD_OPEN;
                  else if (item.target < 16'sd0) mode_in = dms_pkg::MODE_BWD_OPEN;
               end
               target_in = item.target;
               closed_in = 1'b0;
            end
            dms_pkg::OP_THR_CLOSED: begin
               if (mode_ff == dms_pkg::MODE_STOPPED) begin
                  if (item.target > 16'sd0) mode_in = dms_pkg::MODE_FWD_CLOSED;
                  else if (item.target < 16'sd0) mode_in = dms_pkg::MODE_BWD_CLOSED;
               end
               target_in = item.target;
               closed_in = 1'b1;
            end
            dms_pkg::OP_CRAWL: begin
               mode_in   = dms_pkg::MODE_CRAWL;
               target_in = dms_pkg::CRAWL_TARGET;
               closed_in = 1'b1;
            end
            dms_pkg::OP_ODO_RESET: odom_in = '0;
            default: mode_in = mode_ff;
         endcase
      end
   end

   // result fields
   always_comb begin
      result.ack            = 1'b0;
      result.failure        = dms_pkg::FAIL_NONE;
      result.remote_command = dms_pkg::RCMD_NONE;
      result.loop_reset     = 1'b0;
      result.report_valid   = 1'b0;
      if (is_tick) begin
         result.ack          = 1'b1;
         result.loop_reset   = motion_stop || remote_disarm;
         result.report_valid = item.remote_valid;
      end else if (cmd_known && !item.check_ok) begin
         result.failure = dms_pkg::FAIL_CHECKSUM;
      end else if (cmd_ok) begin
         result.failure = cmd_fail;
         result.ack     = (cmd_fail == dms_pkg::FAIL_NONE);
         if (cmd_fail == dms_pkg::FAIL_NONE) begin
            unique case (item.op)
               dms_pkg::OP_ARM:       result.remote_command = dms_pkg::RCMD_ARM;
               dms_pkg::OP_KEEPALIVE: result.remote_command = dms_pkg::RCMD_KEEPALIVE;
               dms_pkg::OP_DISARM:    result.remote_command = dms_pkg::RCMD_DISARM;
               default:               result.remote_command = dms_pkg::RCMD_NONE;
            endcase
         end
      end
      result.mode_out        = mode_in;
      result.throttle_counts = {thr_us_in, {dms_pkg::COUNT_SHIFT{1'b0}}};
      result.steering_counts = {steer_us_in, {dms_pkg::COUNT_SHIFT{1'b0}}};
      result.loop_enable     = closed_in;
      result.target_out      = target_in;
      result.odometer        = odom_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= dms_pkg::MODE_DISABLED;
         target_ff   <= '0;
         closed_ff   <= 1'b0;
         odom_ff     <= '0;
         thr_us_ff   <= dms_pkg::PULSE_RESET_US;
         steer_us_ff <= dms_pkg::PULSE_RESET_US;
      end else if (fire) begin
         mode_ff     <= mode_in;
         target_ff   <= target_in;
         closed_ff   <= closed_in;
         odom_ff     <= odom_in;
         thr_us_ff   <= thr_us_in;
         steer_us_ff <= steer_us_in;
      end
   end

endmodule

FILE: src/drive_mode_supervisor.sv
// top level of the drive mode supervisor: item registers, core and offset registers
//
// Drive mode supervisor. Each item on req_ is either a 20 ms tick or a host
// command and yields exactly one result item on rsp_ carrying ack/failure, the
// mode after the item, both pulse widths in timer counts (16 per us), the
// closed-loop flag and target for the external PID, a PID clear pulse, the
// kill-switch command to send, the odometer and the report flag. An item is
// taken into an input register, evaluated by one pass of mode logic against
// the held state and written to the result register; one item is accepted
// every clock cycle while req_stall is low, and the result is held in the
// result register and driven onto rsp_ from there. req_stall only rises when
// the input register is full and the result register is held by rsp_stall.
// Offset registers are written through csr_ (always ready) and are meant to
// change only while no item is in flight; pulse widths are computed when an
// item passes, so a new offset shows up at the next tick or steering command.
module drive_mode_supervisor (
   input  logic              clock,
   input  logic              reset,
   // item input
   input  logic              req_valid,
   output logic              req_stall,
   input  dms_pkg::req_type  req_item,
   // result output
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dms_pkg::rsp_type  rsp_item,
   // offset register writes
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [11:0]       csr_wdata
);

   dms_pkg::req_type  req_ff, req_in;
   logic              req_valid_ff, req_valid_in;
   dms_pkg::rsp_type  rsp_ff, rsp_in, core_result;
   logic              rsp_valid_ff, rsp_valid_in;
   dms_pkg::csr_type  offsets;
   logic              fire;
   logic              req_take;

   // the held item moves on when the result register is empty or being drained
   assign fire      = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   dms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_ready (csr_ready),
      .offsets   (offsets)
   );

   dms_core u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .item    (req_ff),
      .offsets (offsets),
      .result  (core_result)
   );

   always_comb begin
      // input register: load on acceptance, empty once the item has fired
      req_valid_in = req_take || (req_valid_ff && !fire);
      req_in       = req_take ? req_item : req_ff;
      // result register: load on fire, hold while stalled
      rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);
      rsp_in       = fire ? core_result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   // a held item that cannot move stays held
   a_hold_item : assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !fire |=> req_valid_ff)
      else $error("input register lost an item");

   // a refused item never clears the pid nor reports
   a_refused_quiet : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.ack |-> !rsp_item.loop_reset && !rsp_item.report_valid)
      else $error("refused item pulsed loop_reset or report_valid");

   // a failure code always comes with a refusal
   a_fail_nack : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.failure != dms_pkg::FAIL_NONE |-> !rsp_item.ack)
      else $error("failure code with ack");

   // clearing the pid also clears the motion target
   a_reset_target : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.loop_reset |-> rsp_item.target_out == 16'sd0)
      else $error("loop_reset with nonzero target");

   // a kill-switch command is only sent for an accepted command
   a_rcmd_ack : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.remote_command != dms_pkg::RCMD_NONE
      |-> rsp_item.ack && !rsp_item.report_valid)
      else $error("kill-switch command without an accepted command");
`endif

endmodule

FILE: tb/sv/drive_mode_supervisor_tb.sv
// self-checking testbench of the drive mode supervisor with a mode-tracking scoreboard
`timescale 1ns / 100ps

class mode_tracker;
   logic [dms_pkg::OFFSET_W-1:0] steer_left, steer_right, thr_fwd, thr_bwd;
   dms_pkg::mode_type   mode;
   logic signed [15:0]  motion_target;
   logic                closed_loop;
   logic [31:0]         odometer_sum;
   logic signed [15:0]  last_delta;
   logic [15:0]         throttle_pulse, steering_pulse;
   dms_pkg::rsp_type    awaited_results[$];
   int                  errors;

   function new();
      errors = 0;
      steer_left = dms_pkg::OFFSET_RESET;
      steer_right = dms_pkg::OFFSET_RESET;
      thr_fwd = dms_pkg::OFFSET_RESET;
      thr_bwd = dms_pkg::OFFSET_RESET;
      mode = dms_pkg::MODE_DISABLED;
      motion_target = '0;
      closed_loop = 1'b0;
      odometer_sum = '0;
      last_delta = '0;
      throttle_pulse = pulse_counts(0, thr_fwd, thr_bwd);
      steering_pulse = pulse_counts(0, steer_left, steer_right);
   endfunction

   // offset by sign, mean of offsets at zero, saturate to the us range, scale to counts
   function logic [15:0] pulse_counts(int v, int pos_off, int neg_off);
      int w;
      if (v > 0) w = v + pos_off;
      else if (v < 0) w = v + neg_off;
      else w = (pos_off + neg_off) / 2;
      if (w < 0) w = 0;
      if (w > (1 << dms_pkg::PULSE_US_W) - 1) w = (1 << dms_pkg::PULSE_US_W) - 1;
      return 16'(w << dms_pkg::COUNT_SHIFT);
   endfunction

   function void set_offset(logic [1:0] idx, logic [11:0] val);
      case (idx)
         dms_pkg::CSR_STEER_LEFT:  steer_left = val;
         dms_pkg::CSR_STEER_RIGHT: steer_right = val;
         dms_pkg::CSR_THR_FWD:     thr_fwd = val;
         dms_pkg::CSR_THR_BWD:     thr_bwd = val;
      endcase
   endfunction

   function int pending();
      return awaited_results.size();
   endfunction

   function void clear_frame(ref dms_pkg::rsp_type r);
      r.loop_reset = 1'b1;
      motion_target = '0;
      last_delta = '0;
   endfunction

   // apply one accepted item to the mirrored state and queue the result it causes
   function void note_accepted(dms_pkg::req_type it);
      dms_pkg::rsp_type   r;
      logic signed [15:0] tgt, dlt, lout, thr;
      logic [2:0]         fail;
      logic               disabled;
      tgt = it.target;
      dlt = it.tick_delta;
      lout = it.loop_output;
      r = '0;
      r.ack = 1'b1;
      r.failure = dms_pkg::FAIL_NONE;
      r.remote_command = dms_pkg::RCMD_NONE;
      fail = dms_pkg::FAIL_NONE;
      if (it.op == dms_pkg::OP_TICK) begin
         thr = '0;
         odometer_sum = odometer_sum + int'(dlt);
         last_delta = dlt;
         if (mode == dms_pkg::MODE_FWD_OPEN || mode == dms_pkg::MODE_FWD_CLOSED
             || mode == dms_pkg::MODE_CRAWL) begin
            if (lout >= 0) thr = lout;
         end else if (mode == dms_pkg::MODE_BWD_OPEN
                      || mode == dms_pkg::MODE_BWD_CLOSED) begin
            if (lout <= 0) thr = lout;
         end
         if (mode == dms_pkg::MODE_CRAWL && it.bumper_hit) begin
            mode = dms_pkg::MODE_STOPPED;
            thr = '0;
            clear_frame(r);
         end
         if (mode >= dms_pkg::MODE_FWD_OPEN && last_delta == 0 && motion_target == 0) begin
            mode = dms_pkg::MODE_STOPPED;
            thr = '0;
            clear_frame(r);
         end
         throttle_pulse = pulse_counts(thr, thr_fwd, thr_bwd);
         if (it.remote_valid) begin
            r.report_valid = 1'b1;
            if (it.remote_state == dms_pkg::RSTATE_DISARMED) begin
               mode = dms_pkg::MODE_DISABLED;
            end else if (it.remote_state <= dms_pkg::RSTATE_DISARM_SW) begin
               if (mode != dms_pkg::MODE_DISABLING) begin
                  mode = dms_pkg::MODE_DISABLING;
                  clear_frame(r);
                  throttle_pulse = pulse_counts(0, thr_fwd, thr_bwd);
               end
            end else if (it.remote_state == dms_pkg::RSTATE_ARMED) begin
               if (mode == dms_pkg::MODE_DISABLED || mode == dms_pkg::MODE_DISABLING)
                  mode = dms_pkg::MODE_STOPPED;
            end
         end
      end else if (it.op > dms_pkg::OP_ODO_RESET) begin
         r.ack = 1'b0;
      end else if (!it.check_ok) begin
         r.ack = 1'b0;
         r.failure = dms_pkg::FAIL_CHECKSUM;
      end else begin
         disabled = (mode == dms_pkg::MODE_DISABLED || mode == dms_pkg::MODE_DISABLING);
         case (it.op)
            dms_pkg::OP_STEER: steering_pulse = pulse_counts(tgt, steer_left, steer_right);
            dms_pkg::OP_THR_OPEN: begin
               if (disabled) fail = dms_pkg::FAIL_DISABLED;
               else if (mode == dms_pkg::MODE_STOPPED) begin
                  if (tgt > 0) mode = dms_pkg::MODE_FWD_OPEN;
                  else if (tgt < 0) mode = dms_pkg::MODE_BWD_OPEN;
               end else if (mode == dms_pkg::MODE_FWD_OPEN || mode == dms_pkg::MODE_FWD_CLOSED
                            || mode == dms_pkg::MODE_CRAWL) begin
                  if (tgt < 0) fail = dms_pkg::FAIL_TRANSITION;
               end else if (tgt > 0) fail = dms_pkg::FAIL_TRANSITION;
               if (fail == dms_pkg::FAIL_NONE) begin
                  motion_target = tgt;
                  closed_loop = 1'b0;
               end
            end
            dms_pkg::OP_THR_CLOSED: begin
               if (disabled) fail = dms_pkg::FAIL_DISABLED;
               else if (mode == dms_pkg::MODE_STOPPED) begin
                  if (tgt > 0) mode = dms_pkg::MODE_FWD_CLOSED;
                  else if (tgt < 0) mode = dms_pkg::MODE_BWD_CLOSED;
               end else if (mode == dms_pkg::MODE_FWD_CLOSED
                            || mode == dms_pkg::MODE_CRAWL) begin
                  if (tgt < 0) fail = dms_pkg::FAIL_TRANSITION;
               end else if (mode == dms_pkg::MODE_BWD_CLOSED) begin
                  if (tgt > 0) fail = dms_pkg::FAIL_TRANSITION;
               end else fail = dms_pkg::FAIL_TRANSITION;
               if (fail == dms_pkg::FAIL_NONE) begin
                  motion_target = tgt;
                  closed_loop = 1'b1;
               end
            end
            dms_pkg::OP_CRAWL: begin
               if (disabled) fail = dms_pkg::FAIL_DISABLED;
               else if (mode == dms_pkg::MODE_STOPPED || mode == dms_pkg::MODE_CRAWL
                        || mode == dms_pkg::MODE_FWD_CLOSED) begin
                  mode = dms_pkg::MODE_CRAWL;
                  motion_target = dms_pkg::CRAWL_TARGET;
                  closed_loop = 1'b1;
               end else fail = dms_pkg::FAIL_TRANSITION;
            end
            dms_pkg::OP_ARM: begin
               if (mode == dms_pkg::MODE_DISABLED) r.remote_command = dms_pkg::RCMD_ARM;
               else fail = dms_pkg::FAIL_ACTIVE;
            end
            dms_pkg::OP_KEEPALIVE: begin
               if (!disabled) r.remote_command = dms_pkg::RCMD_KEEPALIVE;
               else fail = dms_pkg::FAIL_DISABLED;
            end
            dms_pkg::OP_DISARM: r.remote_command = dms_pkg::RCMD_DISARM;
            default: odometer_sum = '0;
         endcase
         if (fail != dms_pkg::FAIL_NONE) begin
            r.ack = 1'b0;
            r.failure = fail;
         end
      end
      r.mode_out = mode;
      r.throttle_counts = throttle_pulse;
      r.steering_counts = steering_pulse;
      r.loop_enable = closed_loop;
      r.target_out = motion_target;
      r.odometer = odometer_sum;
      awaited_results.push_back(r);
   endfunction

   function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   function void check_rsp(dms_pkg::rsp_type got);
      dms_pkg::rsp_type want;
      if (awaited_results.size() == 0) begin
         errors++;
         $display("%0t unexpected result: expected none, actual %h", $time, got);
         return;
      end
      want = awaited_results.pop_front();
      cmp_field("ack", want.ack, got.ack);
      cmp_field("failure", want.failure, got.failure);
      cmp_field("mode_out", want.mode_out, got.mode_out);
      cmp_field("throttle_counts", want.throttle_counts, got.throttle_counts);
      cmp_field("steering_counts", want.steering_counts, got.steering_counts);
      cmp_field("loop_enable", want.loop_enable, got.loop_enable);
      cmp_field("target_out", want.target_out, got.target_out);
      cmp_field("loop_reset", want.loop_reset, got.loop_reset);
      cmp_field("remote_command", want.remote_command, got.remote_command);
      cmp_field("odometer", want.odometer, got.odometer);
      cmp_field("report_valid", want.report_valid, got.report_valid);
   endfunction
endclass

module drive_mode_supervisor_tb;

   localparam int CYCLE_LIMIT = 400000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   dms_pkg::req_type req_item = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   dms_pkg::rsp_type rsp_item;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [1:0]       csr_index = dms_pkg::CSR_STEER_LEFT;
   logic [11:0]      csr_wdata = '0;

   // set for the closing phase: no gaps and no stalls from here on
   logic        calm = 1'b0;
   int          cycle_count = 0;
   mode_tracker tracker = new();

   drive_mode_supervisor uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog, reckoned far above the slowest legal run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // sample both handshakes at the edge, before any new drive lands;
   // the input is noted first so its expectation is queued ahead of any check
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) tracker.note_accepted(req_item);
         if (rsp_valid && !rsp_stall) tracker.check_rsp(rsp_item);
      end
   end

   // result side: random stall bursts, with the odd long stretch of none
   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 40) == 0) begin
            repeat (30) @(posedge clock);
         end
      end
   end

   function automatic dms_pkg::req_type mk(logic [3:0] op, logic ok,
                                           logic signed [15:0] tgt,
                                           logic signed [15:0] dlt,
                                           logic signed [15:0] lout,
                                           logic bump, logic rv, logic [2:0] rs);
      dms_pkg::req_type it;
      it.op = op;
      it.check_ok = ok;
      it.target = tgt;
      it.tick_delta = dlt;
      it.loop_output = lout;
      it.bumper_hit = bump;
      it.remote_valid = rv;
      it.remote_state = rs;
      return it;
   endfunction

   // 16-bit values leaning on zero, the extremes, and small magnitudes
   function automatic logic [15:0] rand_word16();
      logic [15:0] s;
      s = 16'($urandom_range(1, 300));
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'h7FFF;
         2: return 16'h8000;
         3, 4, 5: return $urandom_range(0, 1) ? s : -s;
         6: return $urandom_range(0, 1) ? 16'h0001 : 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // hold the item until taken; valid stays up between back-to-back items
   task automatic send_item(input dms_pkg::req_type it);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid, let every awaited result come back, then allow the pipe to empty
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // write all four offsets back to back, only while the block is idle
   task automatic load_offsets(input logic [11:0] sl, input logic [11:0] sr,
                               input logic [11:0] tf, input logic [11:0] tb);
      logic [1:0]  idx [4];
      logic [11:0] val [4];
      idx = '{dms_pkg::CSR_STEER_LEFT, dms_pkg::CSR_STEER_RIGHT,
              dms_pkg::CSR_THR_FWD, dms_pkg::CSR_THR_BWD};
      val = '{sl, sr, tf, tb};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         do @(posedge clock); while (!csr_ready);
         tracker.set_offset(idx[i], val[i]);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      dms_pkg::req_type it;
      logic [3:0]       op;
      logic [2:0]       rs;
      int               pick;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed walk through the mode machine at reset offsets
      // kill switch reads disarmed, then throttle and keepalive are refused while disabled and arm is accepted
      send_item(mk(dms_pkg::OP_TICK, 1, 0, 0, 0, 0, 1, dms_pkg::RSTATE_DISARMED));
      send_item(mk(dms_pkg::OP_THR_OPEN, 1, 100, 0, 0, 0, 0, 0));
      send_item(mk(dms_pkg::OP_ARM, 1, 0, 0, 0, 0, 0, 0));
      send_item(mk(dms_pkg::OP_KEEPALIVE, 1, 0, 0, 0, 0, 0, 0));
      // bad checksum and unknown op
      send_item(mk(dms_pkg::OP_STEER, 0, 500, 0, 0, 0, 0, 0));
      send_item(mk(4'd15, 1, -1, -1, -1, 1, 1, 3'd7));
      // armed switch brings the block to stopped; arm is then refused
      send_item(mk(dms_pkg::OP_TICK, 1, 0, 3, 0, 0, 1, dms_pkg::RSTATE_ARMED));
      send_item(mk(dms_pkg::OP_ARM, 1, 0, 0, 0, 0, 0, 0));
      // steering saturates at both ends and centers at zero
      send_item(mk(dms_pkg::OP_STEER, 1, 32767, 0, 0, 0, 0, 0));
      send_item(mk(dms_pkg::OP_STEER, 1, -32768, 0, 0, 0, 0, 0));
      send_item(mk(dms_pkg::OP_STEER, 1, 0, 0, 0, 0, 0, 0));
      // forward open loop, gated controller output, refused transitions
      send_item(mk(dms_pkg::OP_THR_OPEN, 1, 100, 0, 0, 0, 0, 0));
      send_item(mk(dms_pkg::OP_TICK, 1, 0, 5, 200, 0, 1, dms_pkg::RSTATE_ARMED));
      send_item(mk(dms_pkg::OP_TICK, 1, 0, 5, -200, 0, 0, 0));
      send_item(mk(dms_pkg::OP_THR_CLOSED, 1, 300, 0, 0, 0, 0, 0));
      send_item(mk(dms_pkg::OP_THR_OPEN, 1, -3, 0, 0, 0, 0, 0));
      send_item(mk(dms_pkg::OP_CRAWL, 1, 0, 0, 0, 0, 0, 0));
      // zero target and zero motion stop the vehicle
      send_item(mk(dms_pkg::OP_THR_OPEN, 1, 0, 0, 0, 0, 0, 0));
      send_item(mk(dms_pkg::OP_TICK, 1, 0, 0, 32767, 0, 1, dms_pkg::RSTATE_ARMED));
      // crawl stopped by the bumper
      send_item(mk(dms_pkg::OP_CRAWL, 1, 0, 0, 0, 0, 0, 0));
      send_item(mk(dms_pkg::OP_TICK, 1, 0, 7, 32767, 1, 1, dms_pkg::RSTATE_ARMED));
      // backward closed loop, then an open-loop command keeps the mode
      send_item(mk(dms_pkg::OP_THR_CLOSED, 1, -200, 0, 0, 0, 0, 0));
      send_item(mk(dms_pkg::OP_TICK, 1, 0, -32768, -32768, 0, 1, dms_pkg::RSTATE_ARMED));
      send_item(mk(dms_pkg::OP_THR_OPEN, 1, -7, 0, 0, 0, 0, 0));
      send_item(mk(dms_pkg::OP_KEEPALIVE, 1, 0, 0, 0, 0, 0, 0));
      // disarm from the switch, unknown switch state, failed read
      send_item(mk(dms_pkg::OP_TICK, 1, 0, 32767, 0, 0, 1, dms_pkg::RSTATE_DISARM_REMOTE));
      send_item(mk(dms_pkg::OP_TICK, 1, 0, 1, 0, 0, 1, 3'd6));
      send_item(mk(dms_pkg::OP_TICK, 1, 0, 1, 0, 0, 0, dms_pkg::RSTATE_DISARMED));
      send_item(mk(dms_pkg::OP_DISARM, 1, 0, 0, 0, 0, 0, 0));
      send_item(mk(dms_pkg::OP_ODO_RESET, 1, 0, 0, 0, 0, 0, 0));

      // random phases, each under its own offset setting
      for (int phase = 0; phase < 7; phase++) begin
         settle();
         case (phase)
            0: load_offsets(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
            1: load_offsets(12'd0, 12'd0, 12'd0, 12'd0);
            2: load_offsets(12'd4095, 12'd4095, 12'd4095, 12'd4095);
            3: load_offsets(12'd0, 12'd4095, 12'd4095, 12'd0);
            4: load_offsets(12'd4095, 12'd0, 12'd0, 12'd4095);
            5: load_offsets(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
            default: load_offsets(dms_pkg::OFFSET_RESET, dms_pkg::OFFSET_RESET,
                                  dms_pkg::OFFSET_RESET, dms_pkg::OFFSET_RESET);
         endcase
         if (phase == 6) calm = 1'b1;
         repeat (250) begin
            // mostly ticks and motion commands so the mode machine keeps moving
            pick = $urandom_range(0, 99);
            if (pick < 45) op = dms_pkg::OP_TICK;
            else if (pick < 53) op = dms_pkg::OP_STEER;
            else if (pick < 65) op = dms_pkg::OP_THR_OPEN;
            else if (pick < 77) op = dms_pkg::OP_THR_CLOSED;
            else if (pick < 83) op = dms_pkg::OP_CRAWL;
            else if (pick < 87) op = dms_pkg::OP_ARM;
            else if (pick < 92) op = dms_pkg::OP_KEEPALIVE;
            else if (pick < 95) op = dms_pkg::OP_DISARM;
            else if (pick < 97) op = dms_pkg::OP_ODO_RESET;
            else op = 4'($urandom_range(9, 15));
            // switch mostly armed, with disarm states and unknown codes now and then
            pick = $urandom_range(0, 99);
            if (pick < 78) rs = dms_pkg::RSTATE_ARMED;
            else if (pick < 92) rs = 3'($urandom_range(0, 3));
            else rs = 3'($urandom_range(0, 7));
            it = mk(op, $urandom_range(0, 11) != 0, rand_word16(), rand_word16(),
                    rand_word16(), $urandom_range(0, 9) == 0, $urandom_range(0, 6) != 0, rs);
            send_item(it);
         end
      end

      settle();
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: filelist.f
src/dms_pkg.sv
src/dms_csr.sv
src/dms_pulse.sv
src/dms_core.sv
src/drive_mode_supervisor.sv
tb/sv/drive_mode_supervisor_tb.sv
